### rtl/core/modular_exponentiation_macros.svh
// Assertion macros shared by the RTL; each expects clk_i and rst_ni in scope.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication.
`define MODEXP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("modexp assertion failed");

// Next-cycle implication.
`define MODEXP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("modexp assertion failed");

`endif

### rtl/core/modexp_pkg.sv
`default_nettype none

package modexp_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

  localparam logic [63:0] MODULUS_RESET  = 64'd2;
  localparam logic [63:0] EXPONENT_RESET = 64'd65537;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

`default_nettype wire

### rtl/core/modexp_mulmod.sv
`default_nettype none
`include "modular_exponentiation_macros.svh"

module modexp_mulmod import modexp_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] x_i,
  input  wire logic [WIDTH-1:0] y_i,
  input  wire logic [WIDTH-1:0] n_i,
  output mm_stat_t              stat_o,
  output logic      [WIDTH-1:0] p_o
);

  localparam int unsigned CW = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;

  logic [WIDTH:0]   dbl, dbl_red, sum, sum_red;
  logic [WIDTH-1:0] step;

  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, n_i}) ? dbl - {1'b0, n_i} : dbl;
    sum     = {1'b0, dbl_red[WIDTH-1:0]} + {1'b0, x_q};
    sum_red = (sum >= {1'b0, n_i}) ? sum - {1'b0, n_i} : sum;
    step    = y_q[WIDTH-1] ? sum_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(WIDTH - 1);
      acc_d  = '0;
      x_d    = x_i;
      y_d    = y_i;
    end else if (busy_q) begin
      acc_d = step;
      y_d   = {y_q[WIDTH-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign p_o         = acc_q;

  `MODEXP_ASSERT_NOW(a_no_restart, start_i, !busy_q)
  `MODEXP_ASSERT_NOW(a_done_idle, done_q, !busy_q)
  `MODEXP_ASSERT_NEXT(a_last_step_done, busy_q && !start_i && cnt_q == '0, done_q)

endmodule

`default_nettype wire

### rtl/core/modular_exponentiation.sv
// A modulus below two answers 0, with done_o in the cycle after start_i.
// One item at a time: each product is formed in turn by the shift-add modular multiplier.
// done_o strobes for one cycle with power_residue_o; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears the sequencer; modulus 2, exponent 65537.
`default_nettype none
`include "modular_exponentiation_macros.svh"

module modular_exponentiation import modexp_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WIDTH-1:0]     cfg_wdata_i,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [WIDTH-1:0]     base_i,
  output logic                      done_o,
  output logic [WIDTH-1:0]          power_residue_o
);

  localparam int unsigned BW = $clog2(WIDTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_SQUARE = 2'd2;
  localparam logic [1:0] ST_MULT   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [BW-1:0]    bit_q, bit_d;
  logic             go_q, go_d;
  logic             done_q, done_d;
  logic [WIDTH-1:0] modulus_q, exponent_q;
  logic [WIDTH-1:0] mx_q, mx_d, my_q, my_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] res_q, res_d;

  mm_stat_t         mm_stat;
  logic [WIDTH-1:0] mm_p;
  logic             mod_ok;

  assign mod_ok = |modulus_q[WIDTH-1:1];

  modexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q),
    .x_i     (mx_q),
    .y_i     (my_q),
    .n_i     (modulus_q),
    .stat_o  (mm_stat),
    .p_o     (mm_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= WIDTH'(MODULUS_RESET);
      exponent_q <= WIDTH'(EXPONENT_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODULUS:  modulus_q  <= cfg_wdata_i;
        REG_EXPONENT: exponent_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    go_d    = 1'b0;
    done_d  = 1'b0;
    mx_d    = mx_q;
    my_d    = my_q;
    b_d     = b_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (mod_ok) begin
            // reduce the base as 1 * base mod n
            mx_d    = WIDTH'(1);
            my_d    = base_i;
            go_d    = 1'b1;
            state_d = ST_REDUCE;
          end else begin
            res_d  = '0;
            done_d = 1'b1;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) begin
          b_d     = mm_p;
          bit_d   = BW'(WIDTH - 1);
          mx_d    = WIDTH'(1);
          my_d    = WIDTH'(1);
          go_d    = 1'b1;
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mm_stat.done) begin
          if (exponent_q[bit_q]) begin
            mx_d    = mm_p;
            my_d    = b_q;
            go_d    = 1'b1;
            state_d = ST_MULT;
          end else if (bit_q == '0) begin
            res_d   = mm_p;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            bit_d = bit_q - 1'b1;
            mx_d  = mm_p;
            my_d  = mm_p;
            go_d  = 1'b1;
          end
        end
      end
      ST_MULT: begin
        if (mm_stat.done) begin
          if (bit_q == '0) begin
            res_d   = mm_p;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            bit_d   = bit_q - 1'b1;
            mx_d    = mm_p;
            my_d    = mm_p;
            go_d    = 1'b1;
            state_d = ST_SQUARE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
      go_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      go_q    <= go_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q  <= mx_d;
    my_q  <= my_d;
    b_q   <= b_d;
    res_q <= res_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign power_residue_o = res_q;

  `MODEXP_ASSERT_NOW(a_done_in_idle, done_q, state_q == ST_IDLE)
  `MODEXP_ASSERT_NOW(a_go_while_busy, go_q, state_q != ST_IDLE && !mm_stat.busy)
  `MODEXP_ASSERT_NEXT(a_start_runs, start_i && !busy_o && mod_ok, busy_o && go_q)

endmodule

`default_nettype wire
